### hdl/ccdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdd_pkg
// Shared constants for the character-command differential drive block:
// command characters, register indexes, drive direction codes and widths.
// ----------------------------------------------------------------------------
package ccdd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned RegW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned TurnW  = 9;
  localparam int unsigned HeadW  = 8;
  localparam int unsigned CalcW  = 11;
  localparam int unsigned DirW   = 2;
  localparam int unsigned MagW   = 9;
  localparam int unsigned OutDataW = 32;

  // Command characters.
  localparam logic [CharW-1:0] CmdPlus   = 8'h2B;  // '+'
  localparam logic [CharW-1:0] CmdMinus  = 8'h2D;  // '-'
  localparam logic [CharW-1:0] CmdRight  = 8'h3E;  // '>'
  localparam logic [CharW-1:0] CmdLeft   = 8'h3C;  // '<'
  localparam logic [CharW-1:0] CmdStop   = 8'h20;  // ' '
  localparam logic [CharW-1:0] CmdStraight = 8'h3D; // '='
  localparam logic [CharW-1:0] CmdHeadDn = 8'h72;  // 'r'
  localparam logic [CharW-1:0] CmdHeadUp = 8'h6C;  // 'l'

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSpeedStep  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTurnStep   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinSpeed   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxSpeed   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeadCenter = 3'd4;

  // Register reset values.
  localparam logic [RegW-1:0] SpeedStepRst  = 8'd10;
  localparam logic [RegW-1:0] TurnStepRst   = 8'd10;
  localparam logic [RegW-1:0] MinSpeedRst   = 8'd0;
  localparam logic [RegW-1:0] MaxSpeedRst   = 8'd255;
  localparam logic [RegW-1:0] HeadCenterRst = 8'd90;

  // Drive direction codes.
  localparam logic [DirW-1:0] DirStop    = 2'd0;
  localparam logic [DirW-1:0] DirForward = 2'd1;
  localparam logic [DirW-1:0] DirReverse = 2'd2;

  localparam logic signed [CalcW-1:0] TurnLimit = 11'sd255;
  localparam logic [HeadW-1:0] HeadLimit = 8'd255;

  typedef struct packed {
    logic [DirW-1:0] dir;
    logic [MagW-1:0] mag;
  } drive_t;

endpackage

### hdl/char_command_differential_drive_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_command_differential_drive_top
// Decodes one command character per request, updates speed, turn and head
// levels and reports both drive outputs and the head position.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[7:0] cmd_char
//  m_axis    out        tuser recognized; tdata right_dir, right_mag, left_dir,
//                       left_mag, head_pos
//  cfg       in         write enable, register index, 8-bit data
//
// One request per cycle unless stalled; the result is valid the next cycle.
// The level update, limiting and drive math sit in one combinational pass
// between the level registers and the result register.
// A held result stalls the input only when it is not taken in the same cycle.
// Reset loads the reset value of the head center register into the head level
// and zeroes speed and turn.
// ----------------------------------------------------------------------------
module char_command_differential_drive_top
  import ccdd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CharW-1:0]    s_axis_tdata_i,   // [7:0] cmd_char
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] right_dir, [10:2] right_mag, [12:11] left_dir, [21:13] left_mag,
  // [29:22] head_pos, [31:30] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o,   // [0] recognized
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  logic [RegW-1:0] speed_step_q, turn_step_q, min_speed_q, max_speed_q;
  logic signed [SpeedW-1:0] speed_q, speed_d;
  logic signed [TurnW-1:0]  turn_q, turn_d;
  logic [HeadW-1:0]         head_q, head_d;
  logic                     out_valid_q;
  logic                     recog_q, recog_d;
  drive_t                   right_q, right_d, left_q, left_d;
  logic                     accept;

  logic signed [CalcW-1:0] speed_raw, speed_lim, turn_raw, mn, mx, right_v, left_v;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  function automatic drive_t drive_of(input logic signed [CalcW-1:0] v);
    drive_t d;
    logic signed [CalcW-1:0] neg;
    neg = -v;
    if (v > 0) begin
      d.dir = DirForward;
      d.mag = v[MagW-1:0];
    end else if (v < 0) begin
      d.dir = DirReverse;
      d.mag = neg[MagW-1:0];
    end else begin
      d.dir = DirStop;
      d.mag = '0;
    end
    return d;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_step_q  <= SpeedStepRst;
      turn_step_q   <= TurnStepRst;
      min_speed_q   <= MinSpeedRst;
      max_speed_q   <= MaxSpeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegSpeedStep:  speed_step_q  <= cfg_data_i;
        RegTurnStep:   turn_step_q   <= cfg_data_i;
        RegMinSpeed:   min_speed_q   <= cfg_data_i;
        RegMaxSpeed:   max_speed_q   <= cfg_data_i;
        // The head center only counts at reset, where it always holds its
        // reset value, so a write to it has no effect.
        RegHeadCenter: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    speed_raw = CalcW'(speed_q);
    turn_raw  = CalcW'(turn_q);
    head_d    = head_q;
    recog_d   = 1'b1;
    unique case (s_axis_tdata_i)
      CmdPlus:     speed_raw = CalcW'(speed_q) + $signed({3'b000, speed_step_q});
      CmdMinus:    speed_raw = CalcW'(speed_q) - $signed({3'b000, speed_step_q});
      CmdRight:    turn_raw  = CalcW'(turn_q) + $signed({3'b000, turn_step_q});
      CmdLeft:     turn_raw  = CalcW'(turn_q) - $signed({3'b000, turn_step_q});
      CmdStop: begin
        speed_raw = '0;
        turn_raw  = '0;
      end
      CmdStraight: turn_raw = '0;
      CmdHeadDn:   if (head_q != '0) head_d = head_q - 1'b1;
      CmdHeadUp:   if (head_q != HeadLimit) head_d = head_q + 1'b1;
      default:     recog_d = 1'b0;
    endcase

    // Turn saturates symmetrically.
    if (turn_raw > TurnLimit) turn_raw = TurnLimit;
    else if (turn_raw < -TurnLimit) turn_raw = -TurnLimit;
    turn_d = turn_raw[TurnW-1:0];

    // Dead band limiting: the max bound wins when min exceeds max on the
    // positive side, the min bound wins on the negative side.
    mn = $signed({3'b000, min_speed_q});
    mx = $signed({3'b000, max_speed_q});
    speed_lim = speed_raw;
    if (speed_raw > 0) begin
      if (speed_lim < mn) speed_lim = mn;
      if (speed_lim > mx) speed_lim = mx;
    end else if (speed_raw < 0) begin
      if (speed_lim < -mx) speed_lim = -mx;
      if (speed_lim > -mn) speed_lim = -mn;
    end
    speed_d = speed_lim[SpeedW-1:0];

    right_v = speed_lim - turn_raw;
    left_v  = speed_lim + turn_raw;
    if (right_v > mx) right_v = mx;
    if (left_v > mx) left_v = mx;
    right_d = drive_of(right_v);
    left_d  = drive_of(left_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      turn_q      <= '0;
      head_q      <= HeadCenterRst;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        speed_q     <= speed_d;
        turn_q      <= turn_d;
        head_q      <= head_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      recog_q <= recog_d;
      right_q <= right_d;
      left_q  <= left_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = recog_q;
  assign m_axis_tdata_o  = {2'b00, head_q, left_q.mag, left_q.dir, right_q.mag, right_q.dir};

`ifndef ASSERT_OFF
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed_q <= 10'sd255) && (speed_q >= -10'sd255))
    else $error("speed level out of range");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (turn_q <= 9'sd255) && (turn_q >= -9'sd255))
    else $error("turn level out of range");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tdata_i == CmdStop) |=> (speed_q == '0) && (turn_q == '0))
    else $error("stop command did not clear speed and turn");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tdata_i != CmdHeadDn) && (s_axis_tdata_i != CmdHeadUp)
    |=> $stable(head_q) && m_axis_tvalid_o && (m_axis_tdata_o[29:22] == head_q))
    else $error("head moved or result missing");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for char_command_differential_drive_top. A short
// scripted run of commands is followed by phases of random commands under
// different register settings; a behavioral model of the speed, turn and head
// levels predicts every drive report, which is compared field by field with
// the block's output while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ccdd_pkg::*;

  localparam int ScriptLen = 20;
  localparam int LongHold  = 300;

  typedef struct packed {
    logic             known;
    drive_t           right;
    drive_t           left;
    logic [HeadW-1:0] head;
  } drive_report_t;

  typedef struct packed {
    logic [CharW-1:0] cmd;
    logic             fixed_exp;
    drive_report_t    res;
  } cmd_row_t;

  localparam drive_t        StopDrv = {DirStop, 9'd0};
  localparam drive_report_t NoCheck = '0;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [CharW-1:0]    s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [RegW-1:0]     cfg_data_i;

  // Model of the block: register copies and the three levels.
  int step_speed, step_turn, reg_min, reg_max;
  int speed_lvl, turn_lvl, head_lvl;

  drive_report_t drive_reports_due[$];
  int  mismatches = 0;
  int  hold_asks  = 0;
  int  holds_done = 0;
  bit  idle_on    = 1'b1;

  // Scripted opening; typed expectations hold only where they are obvious.
  cmd_row_t script [ScriptLen] = '{
    {8'h00,       1'b1, {1'b0, StopDrv, StopDrv, HeadCenterRst}},
    {8'hFF,       1'b1, {1'b0, StopDrv, StopDrv, HeadCenterRst}},
    {CmdPlus,     1'b1, {1'b1, {DirForward, 9'd10}, {DirForward, 9'd10}, HeadCenterRst}},
    {CmdRight,    1'b1, {1'b1, StopDrv, {DirForward, 9'd20}, HeadCenterRst}},
    {CmdRight,    1'b0, NoCheck},
    {CmdStraight, 1'b0, NoCheck},
    {CmdMinus,    1'b0, NoCheck},
    {CmdMinus,    1'b0, NoCheck},
    {CmdLeft,     1'b0, NoCheck},
    {CmdStop,     1'b1, {1'b1, StopDrv, StopDrv, HeadCenterRst}},
    {CmdHeadDn,   1'b1, {1'b1, StopDrv, StopDrv, 8'd89}},
    {CmdHeadUp,   1'b1, {1'b1, StopDrv, StopDrv, HeadCenterRst}},
    {CmdHeadUp,   1'b0, NoCheck},
    {8'h2A,       1'b0, NoCheck},
    {8'h2C,       1'b0, NoCheck},
    {8'h3F,       1'b0, NoCheck},
    {8'h52,       1'b0, NoCheck},
    {8'h4C,       1'b0, NoCheck},
    {8'h80,       1'b0, NoCheck},
    {8'h7F,       1'b0, NoCheck}
  };

  char_command_differential_drive_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic drive_t drive_code(input int v);
    drive_t d;
    if (v > 0) begin
      d.dir = DirForward;
      d.mag = MagW'(v);
    end else if (v < 0) begin
      d.dir = DirReverse;
      d.mag = MagW'(-v);
    end else begin
      d = StopDrv;
    end
    return d;
  endfunction

  // Applies one command to the model levels and returns the drive report.
  function automatic drive_report_t apply_command(input logic [CharW-1:0] c);
    drive_report_t res;
    int rgt, lft;
    res.known = 1'b1;
    case (c)
      CmdPlus:     speed_lvl = speed_lvl + step_speed;
      CmdMinus:    speed_lvl = speed_lvl - step_speed;
      CmdRight:    turn_lvl = clip(turn_lvl + step_turn, -int'(TurnLimit), int'(TurnLimit));
      CmdLeft:     turn_lvl = clip(turn_lvl - step_turn, -int'(TurnLimit), int'(TurnLimit));
      CmdStop: begin
        speed_lvl = 0;
        turn_lvl  = 0;
      end
      CmdStraight: turn_lvl = 0;
      CmdHeadDn:   head_lvl = clip(head_lvl - 1, 0, int'(HeadLimit));
      CmdHeadUp:   head_lvl = clip(head_lvl + 1, 0, int'(HeadLimit));
      default:     res.known = 1'b0;
    endcase
    // Dead band: raise to the minimum first, then cap at the maximum, so a
    // minimum above the maximum leaves positive levels at the maximum.
    if (speed_lvl > 0) begin
      if (speed_lvl < reg_min) speed_lvl = reg_min;
      if (speed_lvl > reg_max) speed_lvl = reg_max;
    end else if (speed_lvl < 0) begin
      if (speed_lvl < -reg_max) speed_lvl = -reg_max;
      if (speed_lvl > -reg_min) speed_lvl = -reg_min;
    end
    rgt = speed_lvl - turn_lvl;
    lft = speed_lvl + turn_lvl;
    if (rgt > reg_max) rgt = reg_max;
    if (lft > reg_max) lft = reg_max;
    res.right = drive_code(rgt);
    res.left  = drive_code(lft);
    res.head  = HeadW'(head_lvl);
    return res;
  endfunction

  function automatic logic [CharW-1:0] pick_cmd(input logic [CharW-1:0] fav,
                                               input int fav_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < fav_pct) return fav;
    if (roll >= 90) return CharW'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       return CmdPlus;
      1:       return CmdMinus;
      2:       return CmdRight;
      3:       return CmdLeft;
      4:       return CmdStop;
      5:       return CmdStraight;
      6:       return CmdHeadDn;
      default: return CmdHeadUp;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegSpeedStep:  step_speed = int'(val);
      RegTurnStep:   step_turn  = int'(val);
      RegMinSpeed:   reg_min    = int'(val);
      RegMaxSpeed:   reg_max    = int'(val);
      default: ;
    endcase
  endtask

  // The head center only takes effect at reset, so its writes must not
  // move the head; indexes past the list must be ignored.
  task automatic load_settings(input logic [RegW-1:0] ss, ts, mn, mx, hc);
    int a;
    write_reg(RegSpeedStep, ss);
    write_reg(RegTurnStep, ts);
    write_reg(RegMinSpeed, mn);
    write_reg(RegMaxSpeed, mx);
    write_reg(RegHeadCenter, hc);
    for (a = RegHeadCenter + 1; a < (1 << CfgIdxW); a++)
      write_reg(CfgIdxW'(a), RegW'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_cmd(input logic [CharW-1:0] c, input logic fixed_exp,
                           input drive_report_t fixed_res);
    drive_report_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= CharW'($urandom_range(0, 255));
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_command(c);
    drive_reports_due.push_back(fixed_exp ? fixed_res : predicted);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (drive_reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [RegW-1:0] ss, ts, mn, mx, hc,
                           input logic [CharW-1:0] fav, input int fav_pct,
                           input int n_items, input bit long_hold);
    wait_drained();
    load_settings(ss, ts, mn, mx, hc);
    if (long_hold) hold_asks++;
    repeat (n_items) offer_cmd(pick_cmd(fav, fav_pct), 1'b0, NoCheck);
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] expv,
                               input logic [31:0] actv);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expv, actv);
  endtask

  // Result side: random stalls, plus one long hold-off per request from
  // the stimulus so that the block backs up and stalls its input.
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    drive_report_t due;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (drive_reports_due.size() == 0) begin
        flag_mismatch("unrequested result", '0, m_axis_tdata_o);
      end else begin
        due = drive_reports_due.pop_front();
        if (m_axis_tuser_o !== due.known)
          flag_mismatch("recognized", 32'(due.known), 32'(m_axis_tuser_o));
        if (m_axis_tdata_o[1:0] !== due.right.dir)
          flag_mismatch("right_dir", 32'(due.right.dir), 32'(m_axis_tdata_o[1:0]));
        if (m_axis_tdata_o[10:2] !== due.right.mag)
          flag_mismatch("right_mag", 32'(due.right.mag), 32'(m_axis_tdata_o[10:2]));
        if (m_axis_tdata_o[12:11] !== due.left.dir)
          flag_mismatch("left_dir", 32'(due.left.dir), 32'(m_axis_tdata_o[12:11]));
        if (m_axis_tdata_o[21:13] !== due.left.mag)
          flag_mismatch("left_mag", 32'(due.left.mag), 32'(m_axis_tdata_o[21:13]));
        if (m_axis_tdata_o[29:22] !== due.head)
          flag_mismatch("head_pos", 32'(due.head), 32'(m_axis_tdata_o[29:22]));
        if (m_axis_tdata_o[31:30] !== 2'b00)
          flag_mismatch("tdata padding", '0, 32'(m_axis_tdata_o[31:30]));
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_data_i      = '0;
    step_speed = int'(SpeedStepRst);
    step_turn  = int'(TurnStepRst);
    reg_min    = int'(MinSpeedRst);
    reg_max    = int'(MaxSpeedRst);
    speed_lvl  = 0;
    turn_lvl   = 0;
    head_lvl   = int'(HeadCenterRst);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) offer_cmd(script[i].cmd, script[i].fixed_exp, script[i].res);

    // Reset settings, head driven into its upper stop.
    run_phase(SpeedStepRst, TurnStepRst, MinSpeedRst, MaxSpeedRst, HeadCenterRst,
              CmdHeadUp, 70, 300, 1'b0);
    // Largest steps: speed and turn saturate at once, head driven to zero.
    run_phase(8'd255, 8'd255, 8'd0, 8'd255, 8'd0, CmdHeadDn, 75, 400, 1'b1);
    // Minimum above maximum.
    run_phase(RegW'($urandom_range(1, 255)), RegW'($urandom_range(1, 255)), 8'd200, 8'd50,
              RegW'($urandom_range(0, 255)), CmdPlus, 15, 150, 1'b0);
    // Zero steps leave the levels alone; tiny maximum.
    run_phase(8'd0, 8'd0, 8'd0, 8'd1, 8'd255, CmdMinus, 10, 50, 1'b0);
    // Dead band and cap both at the top.
    run_phase(RegW'($urandom_range(1, 255)), RegW'($urandom_range(1, 255)), 8'd255, 8'd255,
              RegW'($urandom_range(0, 255)), CmdPlus, 10, 100, 1'b0);
    for (int p = 0; p < 5; p++)
      run_phase(RegW'($urandom_range(0, 255)), RegW'($urandom_range(0, 255)),
                RegW'($urandom_range(0, 255)), RegW'($urandom_range(0, 255)),
                RegW'($urandom_range(0, 255)), CmdStop, 0, 100, p == 2);

    idle_on = 1'b0;
    run_phase(RegW'($urandom_range(1, 255)), RegW'($urandom_range(1, 255)),
              RegW'($urandom_range(0, 40)), RegW'($urandom_range(100, 255)),
              RegW'($urandom_range(0, 255)), CmdStop, 0, 100, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && drive_reports_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
